/* sv/assert_macros.svh */
// assertion helpers used by the controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pli_pkg.sv */
`default_nettype none

package pli_pkg;

    // fixed field widths
    localparam int CFG_W    = 5;
    localparam int IDX_IN_W = 4;

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    // result region codes
    typedef enum logic [1:0] {
        REG_BELOW  = 2'd0,
        REG_INTERP = 2'd1,
        REG_ABOVE  = 2'd2
    } t_region;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic wr;
        logic start;
        logic adv;
        logic sel_first;
        logic sel_above;
        logic div_init;
        logic div_step;
        logic finish;
        logic load_out;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic arg_lt_x;
        logic idx_zero;
        logic idx_last;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* sv/pli_ctrl.sv */
`default_nettype none
`include "assert_macros.svh"

module pli_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_kind,
    input  pli_pkg::t_sts i_sts,
    output pli_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);
    import pli_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_kind == KIND_EVAL) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (i_sts.arg_lt_x) begin
                    n_state = i_sts.idx_zero ? ST_DONE : ST_DIV;
                end else if (i_sts.idx_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // command decode
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.wr    = i_in_valid && i_kind == KIND_WRITE;
                o_cmd.start = i_in_valid && i_kind == KIND_EVAL;
            end
            ST_CMP: begin
                if (i_sts.arg_lt_x) begin
                    o_cmd.sel_first = i_sts.idx_zero;
                    o_cmd.div_init  = !i_sts.idx_zero;
                end else if (i_sts.idx_last) begin
                    o_cmd.sel_above = 1'b1;
                end else begin
                    o_cmd.adv = 1'b1;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_FIN: begin
                o_cmd.finish = 1'b1;
            end
            ST_DONE: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // checks
    `ASSERT_NEXT(a_div_ends, i_clk, i_rst_n, r_state == ST_DIV && i_sts.div_last,
        r_state == ST_FIN, "divider did not hand over to finish")
    `ASSERT_IMPL(a_load_free, i_clk, i_rst_n, o_cmd.load_out, i_sts.out_free,
        "result loaded over a waiting result")
    `ASSERT_NEXT(a_scan_on, i_clk, i_rst_n,
        r_state == ST_CMP && !i_sts.arg_lt_x && !i_sts.idx_last,
        r_state == ST_READ, "scan stopped before last entry")

endmodule

`default_nettype wire

/* sv/pli_datapath.sv */
`default_nettype none

module pli_datapath #(
    parameter int TABLE_DEPTH  = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pli_pkg::t_cmd                       i_cmd,
    output pli_pkg::t_sts                       o_sts,
    input  logic                                i_cfg_we,
    input  logic [pli_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic [pli_pkg::IDX_IN_W-1:0]        i_entry_index,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_point_x,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_point_y,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_argument,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]      o_value,
    output logic [1:0]                          o_region
);
    import pli_pkg::*;

    localparam int S     = SAMPLE_WIDTH;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW    = (CFG_W > IDX_W + 1) ? CFG_W : IDX_W + 1;
    localparam int EW    = (IDX_IN_W > IDX_W + 1) ? IDX_IN_W : IDX_W + 1;
    localparam int BIT_W = $clog2(SAMPLE_WIDTH);

    // breakpoint memories
    logic signed [S-1:0] r_mem_x [TABLE_DEPTH];
    logic signed [S-1:0] r_mem_y [TABLE_DEPTH];

    logic [CFG_W-1:0]    r_points;
    logic signed [S-1:0] r_arg;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_last;
    logic signed [S-1:0] r_rd_x;
    logic signed [S-1:0] r_rd_y;
    logic signed [S-1:0] r_x0;
    logic signed [S-1:0] r_y0;
    logic [S-1:0]        r_a;
    logic [S-1:0]        r_d;
    logic [S-1:0]        r_m;
    logic                r_neg;
    logic [S-1:0]        r_q;
    logic [S-1:0]        r_r;
    logic [BIT_W-1:0]    r_bit;
    logic signed [S-1:0] r_res;
    t_region             r_region;
    logic                r_out_valid;
    logic signed [S-1:0] r_out_value;
    t_region             r_out_region;

    logic [CW-1:0]       w_cfg;
    logic [IDX_W-1:0]    w_last;
    logic signed [S:0]   w_a;
    logic signed [S:0]   w_d;
    logic signed [S:0]   w_dy;
    logic signed [S:0]   w_m;
    logic [S+1:0]        w_t;
    logic [S+1:0]        w_d1;
    logic [S+1:0]        w_d2;
    logic [S+1:0]        w_rn;
    logic [1:0]          w_inc;
    logic [S:0]          w_qn;
    logic signed [S:0]   w_sum;
    logic                w_out_free;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= CFG_W'(1);
        end else if (i_cfg_we) begin
            r_points <= i_cfg_wdata;
        end
    end

    // last index in use, saturated to the table
    always_comb begin
        w_cfg = CW'(r_points);
        if (w_cfg == '0) begin
            w_last = '0;
        end else if (w_cfg >= CW'(TABLE_DEPTH)) begin
            w_last = IDX_W'(TABLE_DEPTH - 1);
        end else begin
            w_last = IDX_W'(w_cfg - CW'(1));
        end
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && EW'(i_entry_index) < EW'(TABLE_DEPTH)) begin
            r_mem_x[IDX_W'(i_entry_index)] <= i_point_x;
            r_mem_y[IDX_W'(i_entry_index)] <= i_point_y;
        end
        r_rd_x <= r_mem_x[r_idx];
        r_rd_y <= r_mem_y[r_idx];
    end

    // segment differences
    always_comb begin
        w_a  = {r_arg[S-1], r_arg} - {r_x0[S-1], r_x0};
        w_d  = {r_rd_x[S-1], r_rd_x} - {r_x0[S-1], r_x0};
        w_dy = {r_rd_y[S-1], r_rd_y} - {r_y0[S-1], r_y0};
        w_m  = w_dy[S] ? -w_dy : w_dy;
    end

    // one multiply-divide step: shift in a multiplier bit, reduce below d
    always_comb begin
        w_t  = {1'b0, r_r, 1'b0} + (r_m[S-1] ? {2'b00, r_a} : '0);
        w_d1 = {2'b00, r_d};
        w_d2 = {1'b0, r_d, 1'b0};
        if (w_t >= w_d2) begin
            w_rn  = w_t - w_d2;
            w_inc = 2'd2;
        end else if (w_t >= w_d1) begin
            w_rn  = w_t - w_d1;
            w_inc = 2'd1;
        end else begin
            w_rn  = w_t;
            w_inc = 2'd0;
        end
        w_qn = {r_q, 1'b0} + (S+1)'(w_inc);
    end

    // final offset from the lower ordinate
    always_comb begin
        if (r_neg) begin
            w_sum = {r_y0[S-1], r_y0} - {1'b0, r_q};
        end else begin
            w_sum = {r_y0[S-1], r_y0} + {1'b0, r_q};
        end
    end

    // scan, divide and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_arg  <= i_argument;
            r_idx  <= '0;
            r_last <= w_last;
        end
        if (i_cmd.adv) begin
            r_x0  <= r_rd_x;
            r_y0  <= r_rd_y;
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.sel_first) begin
            r_res    <= r_rd_y;
            r_region <= REG_BELOW;
        end
        if (i_cmd.sel_above) begin
            r_res    <= r_rd_y;
            r_region <= REG_ABOVE;
        end
        if (i_cmd.div_init) begin
            r_a   <= w_a[S-1:0];
            r_d   <= w_d[S-1:0];
            r_m   <= w_m[S-1:0];
            r_neg <= w_dy[S];
            r_q   <= '0;
            r_r   <= '0;
            r_bit <= BIT_W'(S - 1);
        end
        if (i_cmd.div_step) begin
            r_r   <= w_rn[S-1:0];
            r_q   <= w_qn[S-1:0];
            r_m   <= {r_m[S-2:0], 1'b0};
            r_bit <= r_bit - BIT_W'(1);
        end
        if (i_cmd.finish) begin
            r_res    <= w_sum[S-1:0];
            r_region <= REG_INTERP;
        end
    end

    // output register
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_value  <= r_res;
            r_out_region <= r_region;
        end
    end

    // status
    always_comb begin
        o_sts.arg_lt_x = r_arg < r_rd_x;
        o_sts.idx_zero = (r_idx == '0);
        o_sts.idx_last = (r_idx == r_last);
        o_sts.div_last = (r_bit == '0);
        o_sts.out_free = w_out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_region    = r_out_region;

endmodule

`default_nettype wire

/* sv/piecewise_linear_interpolator_top.sv */
// breakpoint write: taken while idle, no result
// evaluate: per table entry scanned, a registered memory read, then a compare;
//   for an interpolated point, then the serial multiply-divide and a finish step
// next item taken once the result sits in the output register
// synchronous active-low reset clears control and sets points_in_use to 1; tables unset
`default_nettype none

module piecewise_linear_interpolator_top #(
    parameter int TABLE_DEPTH  = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pli_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_kind,
    input  logic [pli_pkg::IDX_IN_W-1:0]   i_entry_index,
    input  logic signed [SAMPLE_WIDTH-1:0] i_point_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_point_y,
    input  logic signed [SAMPLE_WIDTH-1:0] i_argument,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_value,
    output logic [1:0]                     o_region
);
    import pli_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    pli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // table, divider and output register
    pli_datapath #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_entry_index (i_entry_index),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_argument    (i_argument),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_value       (o_value),
        .o_region      (o_region)
    );

endmodule

`default_nettype wire
